// ===== src/xdwm_pkg.sv =====
`default_nettype none

package xdwm_pkg;

  localparam int CordicSteps = 24;
  localparam int QueueDepth  = 4;
  localparam int QueuePtrW   = $clog2(QueueDepth);
  localparam int QueueCntW   = $clog2(QueueDepth + 1);

  localparam logic signed [31:0] CordicGain = 32'sd652032874;
  localparam logic signed [17:0] HalfSqrt2  = 18'sd46341;

  localparam logic [31:0] AtanTurn [CordicSteps] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef enum logic [1:0] {
    QuadFirst,
    QuadSecond,
    QuadThird,
    QuadFourth
  } quad_e;

  typedef struct packed {
    logic signed [15:0] drive_x;
    logic signed [15:0] drive_y;
    logic signed [15:0] spin_level;
    quad_e              quad;
    logic signed [31:0] resid;
  } cmd_t;

  typedef struct packed {
    logic               vld;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic signed [15:0] drive_x;
    logic signed [15:0] drive_y;
    logic signed [15:0] spin_level;
    quad_e              quad;
  } cordic_t;

endpackage

`default_nettype wire

// ===== src/x_drive_wheel_mixer_core.sv =====
// Path: an accepted input word is written into the four-word command queue, then passes the
// 24 stages of the sine/cosine pipeline and five mixing stages ahead of the output register.
// Throughput: one word per cycle; the whole back pipeline holds while a result waits.
// Reset: asynchronous and active low; it empties the queue and clears every stage's
// valid flag, so the block is ready for a word in the first cycle after reset.
`default_nettype none

module x_drive_wheel_mixer_core #(
  parameter int ANGLE_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] drive_x_i,
  input  logic signed [15:0] drive_y_i,
  input  logic        [15:0] heading_i,
  input  logic signed [15:0] spin_level_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] wheel_zero_o,
  output logic signed [15:0] wheel_one_o,
  output logic signed [15:0] wheel_two_o,
  output logic signed [15:0] wheel_three_o,
  output logic               clipped_o
);
  import xdwm_pkg::*;

  cmd_t    front_cmd;
  cmd_t    head_cmd;
  cordic_t rot;
  logic    push;
  logic    pop;
  logic    queue_full;
  logic    queue_empty;
  logic    adv;

  assign adv = !out_valid_o || out_ready_i;
  assign pop = !queue_empty && adv;

  xdwm_front #(
    .AngleBits (ANGLE_BITS)
  ) u_front (
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .drive_x_i    (drive_x_i),
    .drive_y_i    (drive_y_i),
    .heading_i    (heading_i),
    .spin_level_i (spin_level_i),
    .queue_full_i (queue_full),
    .push_o       (push),
    .cmd_o        (front_cmd)
  );

  xdwm_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (front_cmd),
    .pop_i   (pop),
    .full_o  (queue_full),
    .empty_o (queue_empty),
    .cmd_o   (head_cmd)
  );

  xdwm_cordic u_cordic (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .in_vld_i (pop),
    .cmd_i    (head_cmd),
    .res_o    (rot)
  );

  xdwm_mix u_mix (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .adv_i         (adv),
    .rot_i         (rot),
    .out_valid_o   (out_valid_o),
    .wheel_zero_o  (wheel_zero_o),
    .wheel_one_o   (wheel_one_o),
    .wheel_two_o   (wheel_two_o),
    .wheel_three_o (wheel_three_o),
    .clipped_o     (clipped_o)
  );

endmodule

`default_nettype wire

// ===== src/xdwm_front.sv =====
`default_nettype none

module xdwm_front #(
  parameter int AngleBits = 16
) (
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] drive_x_i,
  input  logic signed [15:0] drive_y_i,
  input  logic        [15:0] heading_i,
  input  logic signed [15:0] spin_level_i,
  input  logic               queue_full_i,
  output logic               push_o,
  output xdwm_pkg::cmd_t     cmd_o
);
  import xdwm_pkg::*;

  localparam int          KeepBits = (AngleBits < 16) ? AngleBits : 16;
  localparam logic [15:0] HeadMask = 16'hFFFF << (16 - KeepBits);

  logic [15:0] head_masked;
  logic [15:0] head_shifted;

  // The heading is moved by an eighth of a turn so that the low bits give a
  // residual angle centred on zero within its quadrant.
  assign head_masked  = heading_i & HeadMask;
  assign head_shifted = head_masked + 16'h2000;

  assign in_ready_o = !queue_full_i;
  assign push_o     = in_valid_i && !queue_full_i;

  always_comb begin
    cmd_o.drive_x    = drive_x_i;
    cmd_o.drive_y    = drive_y_i;
    cmd_o.spin_level = spin_level_i;
    cmd_o.quad       = quad_e'(head_shifted[15:14]);
    cmd_o.resid      = signed'({2'b00, head_shifted[13:0], 16'h0000}) - 32'sh2000_0000;
  end

endmodule

`default_nettype wire

// ===== src/xdwm_queue.sv =====
`default_nettype none

module xdwm_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  xdwm_pkg::cmd_t cmd_i,
  input  logic           pop_i,
  output logic           full_o,
  output logic           empty_o,
  output xdwm_pkg::cmd_t cmd_o
);
  import xdwm_pkg::*;

  cmd_t                 mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q;
  logic [QueuePtrW-1:0] rd_ptr_q;
  logic [QueueCntW-1:0] cnt_q;
  logic                 do_push;
  logic                 do_pop;

  assign full_o  = (cnt_q == QueueCntW'(QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign cmd_o   = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + QueueCntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - QueueCntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

`default_nettype wire

// ===== src/xdwm_cordic.sv =====
`default_nettype none

module xdwm_cordic (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              adv_i,
  input  logic              in_vld_i,
  input  xdwm_pkg::cmd_t    cmd_i,
  output xdwm_pkg::cordic_t res_o
);
  import xdwm_pkg::*;

  cordic_t first_d;
  cordic_t st_q [CordicSteps];

  always_comb begin
    first_d.vld        = in_vld_i;
    first_d.x          = CordicGain;
    first_d.y          = '0;
    first_d.z          = cmd_i.resid;
    first_d.drive_x    = cmd_i.drive_x;
    first_d.drive_y    = cmd_i.drive_y;
    first_d.spin_level = cmd_i.spin_level;
    first_d.quad       = cmd_i.quad;
  end

  for (genvar i = 0; i < CordicSteps; i++) begin : g_step
    cordic_t prev;
    cordic_t step_d;

    if (i == 0) begin : g_first
      assign prev = first_d;
    end else begin : g_next
      assign prev = st_q[i-1];
    end

    always_comb begin
      step_d = prev;
      if (!prev.z[31]) begin
        step_d.x = prev.x - (prev.y >>> i);
        step_d.y = prev.y + (prev.x >>> i);
        step_d.z = prev.z - signed'(AtanTurn[i]);
      end else begin
        step_d.x = prev.x + (prev.y >>> i);
        step_d.y = prev.y - (prev.x >>> i);
        step_d.z = prev.z + signed'(AtanTurn[i]);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        st_q[i].vld <= 1'b0;
      end else if (adv_i) begin
        st_q[i] <= step_d;
      end
    end
  end

  assign res_o = st_q[CordicSteps-1];

endmodule

`default_nettype wire

// ===== src/xdwm_mix.sv =====
`default_nettype none

module xdwm_mix (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               adv_i,
  input  xdwm_pkg::cordic_t  rot_i,
  output logic               out_valid_o,
  output logic signed [15:0] wheel_zero_o,
  output logic signed [15:0] wheel_one_o,
  output logic signed [15:0] wheel_two_o,
  output logic signed [15:0] wheel_three_o,
  output logic               clipped_o
);
  import xdwm_pkg::*;

  localparam logic signed [31:0] RoundQ15 = 32'sd16384;
  localparam logic signed [52:0] RoundQ31 = 53'sd1 <<< 30;

  logic               trig_vld_q;
  logic signed [16:0] cos_q;
  logic signed [16:0] sin_q;
  logic signed [15:0] dx_q;
  logic signed [15:0] dy_q;
  logic signed [15:0] spin1_q;

  logic               prod_vld_q;
  logic signed [32:0] cx_q;
  logic signed [32:0] sy_q;
  logic signed [32:0] cy_q;
  logic signed [32:0] sx_q;
  logic signed [15:0] spin2_q;

  logic               vec_vld_q;
  logic signed [33:0] vx_q;
  logic signed [33:0] vy_q;
  logic signed [15:0] spin3_q;

  logic               kv_vld_q;
  logic signed [51:0] kvx_q;
  logic signed [51:0] kvy_q;
  logic signed [15:0] spin4_q;

  logic               sum_vld_q;
  logic signed [52:0] wsum_q [4];
  logic signed [15:0] spin5_q;

  logic               out_valid_q;
  logic signed [15:0] wheel_q [4];
  logic               clipped_q;

  logic signed [31:0] xr;
  logic signed [31:0] yr;
  logic signed [16:0] c_d;
  logic signed [16:0] s_d;
  logic signed [16:0] cos_d;
  logic signed [16:0] sin_d;
  logic signed [15:0] wheel_d [4];
  logic               clipped_d;

  always_comb begin
    xr  = rot_i.x + RoundQ15;
    yr  = rot_i.y + RoundQ15;
    c_d = signed'(xr[31:15]);
    s_d = signed'(yr[31:15]);
    case (rot_i.quad)
      QuadFirst: begin
        cos_d = c_d;
        sin_d = s_d;
      end
      QuadSecond: begin
        cos_d = -s_d;
        sin_d = c_d;
      end
      QuadThird: begin
        cos_d = -c_d;
        sin_d = -s_d;
      end
      QuadFourth: begin
        cos_d = s_d;
        sin_d = -c_d;
      end
      default: begin
        cos_d = c_d;
        sin_d = s_d;
      end
    endcase
  end

  always_comb begin
    logic signed [21:0] lvl;
    logic signed [22:0] tot;
    clipped_d = 1'b0;
    for (int k = 0; k < 4; k++) begin
      lvl = signed'(wsum_q[k][52:31]);
      tot = 23'(lvl) + 23'(spin5_q);
      if (tot > 23'sd32767) begin
        wheel_d[k] = 16'sh7FFF;
        clipped_d  = 1'b1;
      end else if (tot < -23'sd32768) begin
        wheel_d[k] = 16'sh8000;
        clipped_d  = 1'b1;
      end else begin
        wheel_d[k] = tot[15:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trig_vld_q  <= 1'b0;
      prod_vld_q  <= 1'b0;
      vec_vld_q   <= 1'b0;
      kv_vld_q    <= 1'b0;
      sum_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv_i) begin
      trig_vld_q  <= rot_i.vld;
      prod_vld_q  <= trig_vld_q;
      vec_vld_q   <= prod_vld_q;
      kv_vld_q    <= vec_vld_q;
      sum_vld_q   <= kv_vld_q;
      out_valid_q <= sum_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      cos_q   <= cos_d;
      sin_q   <= sin_d;
      dx_q    <= rot_i.drive_x;
      dy_q    <= rot_i.drive_y;
      spin1_q <= rot_i.spin_level;

      cx_q    <= cos_q * dx_q;
      sy_q    <= sin_q * dy_q;
      cy_q    <= cos_q * dy_q;
      sx_q    <= sin_q * dx_q;
      spin2_q <= spin1_q;

      vx_q    <= 34'(cx_q) + 34'(sy_q);
      vy_q    <= 34'(cy_q) - 34'(sx_q);
      spin3_q <= spin2_q;

      kvx_q   <= vx_q * HalfSqrt2;
      kvy_q   <= vy_q * HalfSqrt2;
      spin4_q <= spin3_q;

      wsum_q[0] <= 53'(kvy_q) - 53'(kvx_q) + RoundQ31;
      wsum_q[1] <= -53'(kvx_q) - 53'(kvy_q) + RoundQ31;
      wsum_q[2] <= 53'(kvx_q) - 53'(kvy_q) + RoundQ31;
      wsum_q[3] <= 53'(kvx_q) + 53'(kvy_q) + RoundQ31;
      spin5_q   <= spin4_q;

      wheel_q   <= wheel_d;
      clipped_q <= clipped_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign wheel_zero_o  = wheel_q[0];
  assign wheel_one_o   = wheel_q[1];
  assign wheel_two_o   = wheel_q[2];
  assign wheel_three_o = wheel_q[3];
  assign clipped_o     = clipped_q;

endmodule

`default_nettype wire

// ===== bench/x_drive_wheel_mixer_core_tb.sv =====
module x_drive_wheel_mixer_core_tb;
  import xdwm_pkg::*;

  localparam int AngleBits    = 16;
  localparam int RandomWords  = 1750;
  localparam int DrainCycles  = 40;
  localparam int CycleLimit   = 200000;
  localparam int MaxReported  = 10;
  localparam int DirectedRows = 20;

  localparam longint GainQ30      = 64'sd652032874;
  localparam longint HalfRootTwo  = 64'sd46341;
  localparam logic [31:0] TurnAtan [24] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef struct packed {
    logic signed [15:0] wheel_zero;
    logic signed [15:0] wheel_one;
    logic signed [15:0] wheel_two;
    logic signed [15:0] wheel_three;
    logic               clipped;
  } wheel_set_t;

  typedef struct packed {
    logic signed [15:0] drive_x;
    logic signed [15:0] drive_y;
    logic        [15:0] heading;
    logic signed [15:0] spin_level;
    logic               known;
    wheel_set_t         result;
  } drive_cmd_t;

  logic               clk_i        = 1'b0;
  logic               rst_ni       = 1'b0;
  logic               in_valid_i   = 1'b0;
  logic               in_ready_o;
  logic signed [15:0] drive_x_i    = '0;
  logic signed [15:0] drive_y_i    = '0;
  logic        [15:0] heading_i    = '0;
  logic signed [15:0] spin_level_i = '0;
  logic               out_valid_o;
  logic               out_ready_i  = 1'b0;
  logic signed [15:0] wheel_zero_o;
  logic signed [15:0] wheel_one_o;
  logic signed [15:0] wheel_two_o;
  logic signed [15:0] wheel_three_o;
  logic               clipped_o;

  drive_cmd_t directed_rows [DirectedRows];
  drive_cmd_t drive_commands [$];
  wheel_set_t wheel_levels_due [$];
  int         words_sent  = 0;
  int         fail_count  = 0;
  int         cycle_count = 0;
  int         sender_idle [3] = '{14, 59, 0};
  int         receiver_idle [3] = '{59, 14, 0};

  x_drive_wheel_mixer_core #(
    .ANGLE_BITS(AngleBits)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .drive_x_i    (drive_x_i),
    .drive_y_i    (drive_y_i),
    .heading_i    (heading_i),
    .spin_level_i (spin_level_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .wheel_zero_o (wheel_zero_o),
    .wheel_one_o  (wheel_one_o),
    .wheel_two_o  (wheel_two_o),
    .wheel_three_o(wheel_three_o),
    .clipped_o    (clipped_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic wheel_set_t mix_wheel_levels(drive_cmd_t cmd);
    logic [31:0]        turn;
    logic [31:0]        shifted;
    quad_e              quad;
    longint             z;
    longint             cx;
    longint             sy;
    longint             step_x;
    longint             step_y;
    longint             c;
    longint             s;
    longint             cos_v;
    longint             sin_v;
    longint             dx;
    longint             dy;
    longint             vx;
    longint             vy;
    longint             level;
    longint             sums [4];
    logic signed [15:0] wheels [4];
    wheel_set_t         res;
    turn    = {cmd.heading, 16'h0000} & ~((32'd1 << (32 - AngleBits)) - 32'd1);
    shifted = turn + 32'h2000_0000;
    quad    = quad_e'(shifted[31:30]);
    z       = $signed({34'd0, shifted[29:0]}) - 64'sd536870912;
    cx      = GainQ30;
    sy      = 0;
    for (int i = 0; i < 24; i++) begin
      step_x = sy >>> i;
      step_y = cx >>> i;
      if (z >= 0) begin
        cx = cx - step_x;
        sy = sy + step_y;
        z  = z - $signed({32'd0, TurnAtan[i]});
      end else begin
        cx = cx + step_x;
        sy = sy - step_y;
        z  = z + $signed({32'd0, TurnAtan[i]});
      end
    end
    c = (cx + 64'sd16384) >>> 15;
    s = (sy + 64'sd16384) >>> 15;
    case (quad)
      QuadFirst: begin
        cos_v = c;
        sin_v = s;
      end
      QuadSecond: begin
        cos_v = -s;
        sin_v = c;
      end
      QuadThird: begin
        cos_v = -c;
        sin_v = -s;
      end
      default: begin
        cos_v = s;
        sin_v = -c;
      end
    endcase
    dx = longint'(cmd.drive_x);
    dy = longint'(cmd.drive_y);
    vx = cos_v * dx + sin_v * dy;
    vy = cos_v * dy - sin_v * dx;
    sums[0] = -vx + vy;
    sums[1] = -vx - vy;
    sums[2] = vx - vy;
    sums[3] = vx + vy;
    res.clipped = 1'b0;
    for (int k = 0; k < 4; k++) begin
      level = ((sums[k] * HalfRootTwo + (64'sd1 <<< 30)) >>> 31) + longint'(cmd.spin_level);
      if (level > 32767) begin
        wheels[k]   = 16'sh7FFF;
        res.clipped = 1'b1;
      end else if (level < -32768) begin
        wheels[k]   = 16'sh8000;
        res.clipped = 1'b1;
      end else begin
        wheels[k] = 16'(level);
      end
    end
    res.wheel_zero  = wheels[0];
    res.wheel_one   = wheels[1];
    res.wheel_two   = wheels[2];
    res.wheel_three = wheels[3];
    return res;
  endfunction

  function automatic logic signed [15:0] random_level();
    case ($urandom_range(9))
      0:       return 16'sh8000;
      1:       return 16'sh7FFF;
      2:       return 16'(int'($urandom_range(8)) - 4);
      3, 4:    return 16'(int'($urandom_range(8191)) - 4096);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] random_heading();
    if ($urandom_range(4) == 0) begin
      return 16'($urandom_range(7) * 8192 + $urandom_range(4) - 2);
    end
    return 16'($urandom);
  endfunction

  function automatic int phase_of(int n);
    if (n < DirectedRows + RandomWords / 3) begin
      return 0;
    end
    if (n < DirectedRows + 2 * RandomWords / 3) begin
      return 1;
    end
    return 2;
  endfunction

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= MaxReported) begin
      $display("%s", msg);
    end
  endtask

  always @(posedge clk_i) begin : channels
    int         phase;
    wheel_set_t got;
    wheel_set_t want;
    drive_cmd_t cmd;
    if (rst_ni) begin
      phase = phase_of(words_sent);
      if (out_valid_o && out_ready_i) begin
        got = '{wheel_zero_o, wheel_one_o, wheel_two_o, wheel_three_o, clipped_o};
        if (wheel_levels_due.size() == 0) begin
          note_failure($sformatf("Unexpected result word: %0d %0d %0d %0d clip %0b",
                                 got.wheel_zero, got.wheel_one, got.wheel_two,
                                 got.wheel_three, got.clipped));
        end else begin
          want = wheel_levels_due.pop_front();
          if (got.wheel_zero !== want.wheel_zero || got.wheel_one !== want.wheel_one ||
              got.wheel_two !== want.wheel_two || got.wheel_three !== want.wheel_three ||
              got.clipped !== want.clipped) begin
            note_failure($sformatf(
              "Result word mismatch: expected %0d %0d %0d %0d clip %0b, got %0d %0d %0d %0d clip %0b",
              want.wheel_zero, want.wheel_one, want.wheel_two, want.wheel_three, want.clipped,
              got.wheel_zero, got.wheel_one, got.wheel_two, got.wheel_three, got.clipped));
          end
        end
      end
      out_ready_i <= ($urandom_range(99) >= receiver_idle[phase]);

      if (in_valid_i && in_ready_o) begin
        cmd = drive_commands[words_sent];
        wheel_levels_due.push_back(cmd.known ? cmd.result : mix_wheel_levels(cmd));
        words_sent++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (words_sent < drive_commands.size() &&
            $urandom_range(99) >= sender_idle[phase]) begin
          cmd = drive_commands[words_sent];
          drive_x_i    <= cmd.drive_x;
          drive_y_i    <= cmd.drive_y;
          heading_i    <= cmd.heading;
          spin_level_i <= cmd.spin_level;
          in_valid_i   <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    // With no drive the wheels carry the spin level alone, whatever the heading.
    directed_rows = '{
      '{16'sd0, 16'sd0, 16'h0000, 16'sd0, 1'b1, '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0}},
      '{16'sd0, 16'sd0, 16'h0000, 16'sh7FFF, 1'b1,
        '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b0}},
      '{16'sd0, 16'sd0, 16'hFFFF, 16'sh8000, 1'b1,
        '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 1'b0}},
      '{16'sd0, 16'sd0, 16'h8000, 16'sd1234, 1'b1,
        '{16'sd1234, 16'sd1234, 16'sd1234, 16'sd1234, 1'b0}},
      '{16'sh7FFF, 16'sd0, 16'h0000, 16'sd0, 1'b0, '0},
      '{16'sh7FFF, 16'sd0, 16'h4000, 16'sd0, 1'b0, '0},
      '{16'sh7FFF, 16'sd0, 16'h8000, 16'sd0, 1'b0, '0},
      '{16'sh7FFF, 16'sd0, 16'hC000, 16'sd0, 1'b0, '0},
      '{16'sd0, 16'sh7FFF, 16'h2000, 16'sd0, 1'b0, '0},
      '{16'sd0, 16'sh8000, 16'h1FFF, 16'sd0, 1'b0, '0},
      '{16'sh8000, 16'sh8000, 16'hE000, 16'sd0, 1'b0, '0},
      '{16'sh8000, 16'sh8000, 16'hFFFF, 16'sd0, 1'b0, '0},
      '{16'sh7FFF, 16'sh7FFF, 16'h6000, 16'sh7FFF, 1'b0, '0},
      '{16'sh8000, 16'sh8000, 16'h0000, 16'sh8000, 1'b0, '0},
      '{16'sh8000, 16'sh7FFF, 16'hA000, 16'sd0, 1'b0, '0},
      '{16'sh7FFF, 16'sh8000, 16'h5FFF, 16'sh8000, 1'b0, '0},
      '{16'sh8000, 16'sd0, 16'h0001, 16'sh7FFF, 1'b0, '0},
      '{16'sd1, -16'sd1, 16'h3FFF, -16'sd1, 1'b0, '0},
      '{16'sd12000, -16'sd20000, 16'h1234, 16'sd5000, 1'b0, '0},
      '{16'sh8000, 16'sh8000, 16'h2000, 16'sd0, 1'b0, '0}
    };
    for (int i = 0; i < DirectedRows; i++) begin
      drive_commands.push_back(directed_rows[i]);
    end
    for (int i = 0; i < RandomWords; i++) begin
      drive_commands.push_back('{random_level(), random_level(), random_heading(),
                                 random_level(), 1'b0, '0});
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (words_sent < drive_commands.size() || wheel_levels_due.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);
    if (wheel_levels_due.size() != 0) begin
      note_failure($sformatf("%0d result words never arrived", wheel_levels_due.size()));
    end

    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/xdwm_pkg.sv
src/xdwm_front.sv
src/xdwm_queue.sv
src/xdwm_cordic.sv
src/xdwm_mix.sv
src/x_drive_wheel_mixer_core.sv
bench/x_drive_wheel_mixer_core_tb.sv
